[sv/itp_pkg.sv]
// Shared types, codes and helpers for the infix-to-postfix converter.
// No dependencies; every other file imports this package.
package itp_pkg;

   // Sizing
   localparam int STACK_DEPTH = 32;
   localparam int MANT_BITS   = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   typedef logic [3:0]           op_code_type;
   typedef logic [1:0]           kind_type;
   typedef logic [2:0]           err_type;
   typedef logic [7:0]           char_type;
   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [MANT_BITS-1:0] mant_type;

   // Stacked codes: operators, then the open bracket
   localparam op_code_type OP_ADD  = 4'd0;
   localparam op_code_type OP_SUB  = 4'd1;
   localparam op_code_type OP_MUL  = 4'd2;
   localparam op_code_type OP_DIV  = 4'd3;
   localparam op_code_type OP_POW  = 4'd4;
   localparam op_code_type OP_NEG  = 4'd5;
   localparam op_code_type OP_SIN  = 4'd6;
   localparam op_code_type OP_COS  = 4'd7;
   localparam op_code_type OP_SQRT = 4'd8;
   localparam op_code_type OP_LN   = 4'd9;
   localparam op_code_type CODE_LP = 4'd10;

   // Token kinds
   localparam kind_type KIND_NUM = 2'd0;
   localparam kind_type KIND_VAR = 2'd1;
   localparam kind_type KIND_OP  = 2'd2;
   localparam kind_type KIND_END = 2'd3;

   // Error codes
   localparam err_type ERR_NONE     = 3'd0;
   localparam err_type ERR_STACK    = 3'd1;
   localparam err_type ERR_STRAY_RP = 3'd2;
   localparam err_type ERR_OPEN_LP  = 3'd3;
   localparam err_type ERR_NUMBER   = 3'd4;

   // Characters
   localparam char_type CH_ZERO  = 8'd48;
   localparam char_type CH_NINE  = 8'd57;
   localparam char_type CH_A     = 8'd65;
   localparam char_type CH_Z     = 8'd90;
   localparam char_type CH_TILDE = 8'h7E;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_STAR  = 8'h2A;
   localparam char_type CH_SLASH = 8'h2F;
   localparam char_type CH_CARET = 8'h5E;
   localparam char_type CH_DOT   = 8'h2E;
   localparam char_type CH_LP    = 8'h28;
   localparam char_type CH_RP    = 8'h29;
   localparam char_type CH_LC_S  = 8'h73;
   localparam char_type CH_LC_C  = 8'h63;
   localparam char_type CH_LC_L  = 8'h6C;
   localparam char_type CH_LC_I  = 8'h69;
   localparam char_type CH_LC_Q  = 8'h71;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] mantissa;
      logic [4:0]  point_digits;
      logic [4:0]  var_index;
      logic        first_use;
      op_code_type op_code;
      err_type     error_code;
   } tok_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      op_code_type code;
   } stk_cmd_type;

   typedef struct packed {
      logic        empty;
      logic        full;
      op_code_type top;
   } stk_stat_type;

   // True when op may be pushed above prev without popping prev first.
   function automatic logic may_sit_on(op_code_type op, op_code_type prev);
      logic ok;
      ok = 1'b0;
      if (prev == CODE_LP) begin
         ok = 1'b1;
      end else if (op == OP_MUL || op == OP_DIV) begin
         ok = (prev == OP_ADD) || (prev == OP_SUB);
      end else if (op == OP_POW) begin
         ok = (prev <= OP_POW);
      end
      return ok;
   endfunction

   function automatic logic is_prefix(op_code_type code);
      return (code >= OP_NEG) && (code <= OP_LN);
   endfunction

   function automatic tok_type mk_op_tok(op_code_type op);
      tok_type t;
      t         = '0;
      t.kind    = KIND_OP;
      t.op_code = op;
      return t;
   endfunction

   function automatic tok_type mk_num_tok(mant_type m, logic [4:0] pd);
      tok_type t;
      t              = '0;
      t.kind         = KIND_NUM;
      t.mantissa     = 32'(m);
      t.point_digits = pd;
      return t;
   endfunction

   function automatic tok_type mk_var_tok(logic [4:0] v, logic first);
      tok_type t;
      t           = '0;
      t.kind      = KIND_VAR;
      t.var_index = v;
      t.first_use = first;
      return t;
   endfunction

   function automatic tok_type mk_end_tok(err_type e);
      tok_type t;
      t            = '0;
      t.kind       = KIND_END;
      t.error_code = e;
      return t;
   endfunction

endpackage

[sv/itp_stack_cell.sv]
// One entry of the operator stack: holds a code, shifts with its neighbors.
// Depends on itp_pkg.
module itp_stack_cell (
   input  logic                clock,
   input  itp_pkg::stk_cmd_type cmd,
   input  itp_pkg::op_code_type from_above,
   input  itp_pkg::op_code_type from_below,
   output itp_pkg::op_code_type code_out
);
   import itp_pkg::*;

   op_code_type code_ff;

   // Push moves codes down, pop moves them up
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         code_ff <= from_above;
      end else if (cmd.pop) begin
         code_ff <= from_below;
      end
   end

   assign code_out = code_ff;

endmodule

[sv/itp_op_stack.sv]
// Operator stack built as a row of shifting cells, top at cell zero.
// Depends on itp_pkg and itp_stack_cell.
module itp_op_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  itp_pkg::stk_cmd_type  cmd,
   output itp_pkg::stk_stat_type stat
);
   import itp_pkg::*;

   count_type   count_ff;
   count_type   count_in;
   stk_cmd_type cell_cmd;
   op_code_type codes [STACK_DEPTH];
   logic        full;
   logic        empty;

   assign full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign empty = (count_ff == '0);

   // Drop a push onto a full stack or a pop from an empty one
   always_comb begin
      cell_cmd      = cmd;
      cell_cmd.push = cmd.push && !full;
      cell_cmd.pop  = cmd.pop && !cmd.push && !empty;
      count_in      = count_ff;
      if (cell_cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cell_cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      op_code_type above;
      op_code_type below;
      if (i == 0) begin : g_top
         assign above = cmd.code;
      end else begin : g_mid
         assign above = codes[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = codes[i];
      end else begin : g_inner
         assign below = codes[i+1];
      end
      itp_stack_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .from_above (above),
         .from_below (below),
         .code_out   (codes[i])
      );
   end

   assign stat.empty = empty;
   assign stat.full  = full;
   assign stat.top   = codes[0];

endmodule

[sv/infix_to_postfix_converter_unit.sv]
// Infix-to-postfix converter: one character per word in, postfix tokens out.
// Sequencing: digits, '.', skipped characters and a '~', '(', function letter or ignored character
// are handled in the idle state; a letter that ends a number goes through S_VAR; a binary operator
// first pops each operator that cannot stay under it, then is pushed; ')' pops operators up to its
// bracket, then a prefix operator, if any. With the end flag the pending number is flushed, the
// stack is emptied and the end token goes out. A stall on rsp_ready holds the sequencer.
// Reset clears all control state at once; the stack cells themselves are not cleared.
module infix_to_postfix_converter_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_char_code,
   input  logic                 req_end_of_expr,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_token_kind,
   output logic [31:0]          rsp_mantissa,
   output logic [4:0]           rsp_point_digits,
   output logic [4:0]           rsp_var_index,
   output logic                 rsp_first_use,
   output logic [3:0]           rsp_op_code,
   output logic [2:0]           rsp_error_code,
   output logic                 rsp_last_of_run
);
   import itp_pkg::*;

   localparam int       ACC_W    = MANT_BITS + 4;
   localparam mant_type MANT_MAX = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_VAR, S_BIN, S_CLOSE, S_CLOSE_FN,
      S_END_NUM, S_END_POP, S_END_TOK, S_FINAL
   } state_type;

   typedef enum logic [1:0] {
      SC_IDLE, SC_SPEND, SC_SKIP1, SC_SKIP2
   } scan_type;

   // Control registers
   state_type   state_ff, state_in;
   scan_type    scan_ff, scan_in;
   logic        held_v_ff, held_v_in;
   logic        rsp_v_ff, rsp_v_in;
   logic        num_active_ff, num_active_in;
   logic        point_ff, point_in;
   logic [4:0]  frac_ff, frac_in;
   mant_type    accum_ff, accum_in;
   logic [25:0] seen_ff, seen_in;
   err_type     err_ff, err_in;
   logic        end_ff, end_in;

   // Payload registers
   tok_type     held_ff, held_in;
   tok_type     rsp_tok_ff, rsp_tok_in;
   logic        rsp_last_ff, rsp_last_in;
   op_code_type op_ff, op_in;
   logic [4:0]  var_ff, var_in;

   stk_cmd_type  stk_cmd;
   stk_stat_type stk_stat;

   logic        fire;
   logic        out_free;
   logic        can_produce;
   logic        produce_en;
   tok_type     produce_tok;
   logic        finalize_en;
   logic        err_set;
   err_type     err_code_set;

   // Character decode
   logic        is_digit;
   logic        is_letter;
   char_type    digit_off;
   char_type    letter_off;
   logic [4:0]  letter_idx;
   mant_type    acc_base;
   logic        point_base;
   logic [4:0]  frac_base;
   logic [ACC_W-1:0] acc_ext;
   logic [ACC_W-1:0] acc_prod;
   tok_type     num_tok;

   assign req_ready   = (state_ff == S_IDLE);
   assign fire        = req_valid && req_ready;
   assign out_free    = !rsp_v_ff || rsp_ready;
   assign can_produce = !held_v_ff || out_free;

   assign is_digit   = (req_char_code >= CH_ZERO) && (req_char_code <= CH_NINE);
   assign is_letter  = (req_char_code >= CH_A) && (req_char_code <= CH_Z);
   assign digit_off  = req_char_code - CH_ZERO;
   assign letter_off = req_char_code - CH_A;
   assign letter_idx = letter_off[4:0];

   // A digit starting a new number begins from zero
   assign acc_base   = num_active_ff ? accum_ff : '0;
   assign point_base = num_active_ff ? point_ff : 1'b0;
   assign frac_base  = num_active_ff ? frac_ff : 5'd0;
   assign acc_ext    = ACC_W'(acc_base);
   assign acc_prod   = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(digit_off[3:0]);
   assign num_tok    = mk_num_tok(accum_ff, frac_ff);

   itp_op_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   always_comb begin
      logic     handle;
      logic     act_valid;
      state_type act_state;

      handle        = 1'b0;
      act_valid     = 1'b0;
      act_state     = S_IDLE;
      state_in      = state_ff;
      scan_in       = scan_ff;
      held_v_in     = held_v_ff;
      held_in       = held_ff;
      rsp_v_in      = rsp_v_ff && !rsp_ready;
      rsp_tok_in    = rsp_tok_ff;
      rsp_last_in   = rsp_last_ff;
      num_active_in = num_active_ff;
      point_in      = point_ff;
      frac_in       = frac_ff;
      accum_in      = accum_ff;
      seen_in       = seen_ff;
      err_in        = err_ff;
      end_in        = end_ff;
      op_in         = op_ff;
      var_in        = var_ff;
      stk_cmd       = '0;
      produce_en    = 1'b0;
      produce_tok   = '0;
      finalize_en   = 1'b0;
      err_set       = 1'b0;
      err_code_set  = ERR_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               end_in = req_end_of_expr;
               unique case (scan_ff)
                  SC_SKIP2: scan_in = SC_SKIP1;
                  SC_SKIP1: scan_in = SC_IDLE;
                  SC_SPEND: begin
                     if (req_char_code == CH_LC_I) begin
                        stk_cmd.push = 1'b1;
                        stk_cmd.code = OP_SIN;
                        scan_in      = SC_SKIP1;
                     end else if (req_char_code == CH_LC_Q) begin
                        stk_cmd.push = 1'b1;
                        stk_cmd.code = OP_SQRT;
                        scan_in      = SC_SKIP2;
                     end else begin
                        scan_in = SC_IDLE;
                        handle  = 1'b1;
                     end
                  end
                  default: handle = 1'b1;
               endcase

               if (handle) begin
                  if (is_digit) begin
                     num_active_in = 1'b1;
                     point_in      = point_base;
                     frac_in       = frac_base;
                     accum_in      = acc_base;
                     // Drop digits past the longest fraction
                     if (!(point_base && frac_base == 5'd31)) begin
                        frac_in = frac_base + 5'(point_base);
                        if (acc_prod > ACC_W'(MANT_MAX)) begin
                           accum_in     = MANT_MAX;
                           err_set      = 1'b1;
                           err_code_set = ERR_NUMBER;
                        end else begin
                           accum_in = acc_prod[MANT_BITS-1:0];
                        end
                     end
                  end else if (req_char_code == CH_DOT) begin
                     if (!num_active_ff) begin
                        num_active_in = 1'b1;
                        accum_in      = '0;
                        frac_in       = 5'd0;
                     end
                     point_in = 1'b1;
                  end else begin
                     // Any other character ends a pending number
                     if (num_active_ff) begin
                        produce_en  = 1'b1;
                        produce_tok = num_tok;
                     end
                     num_active_in = 1'b0;
                     point_in      = 1'b0;
                     accum_in      = '0;
                     frac_in       = 5'd0;
                     if (is_letter) begin
                        if (num_active_ff) begin
                           var_in    = letter_idx;
                           act_valid = 1'b1;
                           act_state = S_VAR;
                        end else begin
                           produce_en  = 1'b1;
                           produce_tok = mk_var_tok(letter_idx, !seen_ff[letter_idx]);
                           seen_in[letter_idx] = 1'b1;
                        end
                     end else begin
                        unique case (req_char_code)
                           CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: begin
                              act_valid = 1'b1;
                              act_state = S_BIN;
                              unique case (req_char_code)
                                 CH_PLUS:  op_in = OP_ADD;
                                 CH_MINUS: op_in = OP_SUB;
                                 CH_STAR:  op_in = OP_MUL;
                                 CH_SLASH: op_in = OP_DIV;
                                 default:  op_in = OP_POW;
                              endcase
                           end
                           CH_TILDE: begin
                              stk_cmd.push = 1'b1;
                              stk_cmd.code = OP_NEG;
                           end
                           CH_LC_C: begin
                              stk_cmd.push = 1'b1;
                              stk_cmd.code = OP_COS;
                              scan_in      = SC_SKIP2;
                           end
                           CH_LC_L: begin
                              stk_cmd.push = 1'b1;
                              stk_cmd.code = OP_LN;
                              scan_in      = SC_SKIP1;
                           end
                           CH_LC_S: scan_in = SC_SPEND;
                           CH_LP: begin
                              stk_cmd.push = 1'b1;
                              stk_cmd.code = CODE_LP;
                           end
                           CH_RP: begin
                              act_valid = 1'b1;
                              act_state = S_CLOSE;
                           end
                           default: ;
                        endcase
                     end
                  end
               end

               if (act_valid) begin
                  state_in = act_state;
               end else if (req_end_of_expr) begin
                  state_in = S_END_NUM;
               end else if (produce_en) begin
                  state_in = S_FINAL;
               end
            end
         end

         S_VAR: begin
            if (can_produce) begin
               produce_en      = 1'b1;
               produce_tok     = mk_var_tok(var_ff, !seen_ff[var_ff]);
               seen_in[var_ff] = 1'b1;
               state_in        = end_ff ? S_END_NUM : S_FINAL;
            end
         end

         // Pop what cannot stay under the new operator, then push it
         S_BIN: begin
            if (!stk_stat.empty && !may_sit_on(op_ff, stk_stat.top)) begin
               if (can_produce) begin
                  stk_cmd.pop = 1'b1;
                  produce_en  = 1'b1;
                  produce_tok = mk_op_tok(stk_stat.top);
               end
            end else begin
               stk_cmd.push = 1'b1;
               stk_cmd.code = op_ff;
               state_in     = end_ff ? S_END_NUM : S_FINAL;
            end
         end

         S_CLOSE: begin
            if (stk_stat.empty) begin
               err_set      = 1'b1;
               err_code_set = ERR_STRAY_RP;
               state_in     = end_ff ? S_END_NUM : S_FINAL;
            end else if (stk_stat.top != CODE_LP) begin
               if (can_produce) begin
                  stk_cmd.pop = 1'b1;
                  produce_en  = 1'b1;
                  produce_tok = mk_op_tok(stk_stat.top);
               end
            end else begin
               stk_cmd.pop = 1'b1;
               state_in    = S_CLOSE_FN;
            end
         end

         // A prefix operator right before the group goes out once here
         S_CLOSE_FN: begin
            if (!stk_stat.empty && is_prefix(stk_stat.top)) begin
               if (can_produce) begin
                  stk_cmd.pop = 1'b1;
                  produce_en  = 1'b1;
                  produce_tok = mk_op_tok(stk_stat.top);
                  state_in    = end_ff ? S_END_NUM : S_FINAL;
               end
            end else begin
               state_in = end_ff ? S_END_NUM : S_FINAL;
            end
         end

         S_END_NUM: begin
            if (!num_active_ff) begin
               state_in = S_END_POP;
            end else if (can_produce) begin
               produce_en    = 1'b1;
               produce_tok   = num_tok;
               num_active_in = 1'b0;
               point_in      = 1'b0;
               accum_in      = '0;
               frac_in       = 5'd0;
               state_in      = S_END_POP;
            end
         end

         // Empty the stack, discarding open brackets
         S_END_POP: begin
            if (stk_stat.empty) begin
               state_in = S_END_TOK;
            end else if (stk_stat.top == CODE_LP) begin
               stk_cmd.pop  = 1'b1;
               err_set      = 1'b1;
               err_code_set = ERR_OPEN_LP;
            end else if (can_produce) begin
               stk_cmd.pop = 1'b1;
               produce_en  = 1'b1;
               produce_tok = mk_op_tok(stk_stat.top);
            end
         end

         S_END_TOK: begin
            if (can_produce) begin
               produce_en    = 1'b1;
               produce_tok   = mk_end_tok(err_ff);
               num_active_in = 1'b0;
               point_in      = 1'b0;
               accum_in      = '0;
               frac_in       = 5'd0;
               scan_in       = SC_IDLE;
               seen_in       = '0;
               err_in        = ERR_NONE;
               state_in      = S_FINAL;
            end
         end

         S_FINAL: begin
            if (!held_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               finalize_en = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // A push onto a full stack is dropped by the stack itself
      if (stk_cmd.push && stk_stat.full) begin
         err_set      = 1'b1;
         err_code_set = ERR_STACK;
      end
      if (err_set && err_ff == ERR_NONE) begin
         err_in = err_code_set;
      end

      // Hold the newest token back until it is known whether more follow
      if (produce_en) begin
         if (held_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_tok_in  = held_ff;
            rsp_last_in = 1'b0;
         end
         held_in   = produce_tok;
         held_v_in = 1'b1;
      end else if (finalize_en) begin
         rsp_v_in    = 1'b1;
         rsp_tok_in  = held_ff;
         rsp_last_in = 1'b1;
         held_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      rsp_tok_ff  <= rsp_tok_in;
      rsp_last_ff <= rsp_last_in;
      op_ff       <= op_in;
      var_ff      <= var_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= SC_IDLE;
         held_v_ff     <= 1'b0;
         rsp_v_ff      <= 1'b0;
         num_active_ff <= 1'b0;
         point_ff      <= 1'b0;
         frac_ff       <= 5'd0;
         accum_ff      <= '0;
         seen_ff       <= '0;
         err_ff        <= ERR_NONE;
         end_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         held_v_ff     <= held_v_in;
         rsp_v_ff      <= rsp_v_in;
         num_active_ff <= num_active_in;
         point_ff      <= point_in;
         frac_ff       <= frac_in;
         accum_ff      <= accum_in;
         seen_ff       <= seen_in;
         err_ff        <= err_in;
         end_ff        <= end_in;
      end
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_token_kind   = rsp_tok_ff.kind;
   assign rsp_mantissa     = rsp_tok_ff.mantissa;
   assign rsp_point_digits = rsp_tok_ff.point_digits;
   assign rsp_var_index    = rsp_tok_ff.var_index;
   assign rsp_first_use    = rsp_tok_ff.first_use;
   assign rsp_op_code      = rsp_tok_ff.op_code;
   assign rsp_error_code   = rsp_tok_ff.error_code;
   assign rsp_last_of_run  = rsp_last_ff;

   // A new character never finds a token still held back
   a_idle_held_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !held_v_ff)
      else $error("character accepted with a token still held");

   // The sequencer never pops an empty stack
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      stk_cmd.pop |-> !stk_stat.empty)
      else $error("pop from empty operator stack");

   // The end token always closes its run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_tok_ff.kind == KIND_END) |-> rsp_last_ff)
      else $error("end token not marked last");

   // Only the end token carries an error code
   a_err_on_end_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_tok_ff.kind != KIND_END) |-> (rsp_tok_ff.error_code == ERR_NONE))
      else $error("error code on a non-end token");

   // Issuing the end token clears per-expression state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END_TOK && produce_en) |=>
         (seen_ff == '0 && err_ff == ERR_NONE && stk_stat.empty))
      else $error("expression state not cleared after end token");

endmodule

[dv/itp_token_checker.sv]
`timescale 1ns / 100ps
// Token checker for the infix-to-postfix converter: watches the character and token
// channels, predicts the postfix tokens of every accepted word and compares them.
// Depends on itp_pkg for token types, operator codes, character and error codes.
module itp_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_expr,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_token_kind,
   input  logic [31:0] rsp_mantissa,
   input  logic [4:0]  rsp_point_digits,
   input  logic [4:0]  rsp_var_index,
   input  logic        rsp_first_use,
   input  logic [3:0]  rsp_op_code,
   input  logic [2:0]  rsp_error_code,
   input  logic        rsp_last_of_run,
   output int unsigned mismatches,
   output int unsigned outstanding,
   output int unsigned tokens_checked
);
   import itp_pkg::*;

   typedef enum logic [1:0] {
      NAME_IDLE,
      NAME_S_SEEN,
      NAME_SKIP1,
      NAME_SKIP2
   } name_scan_type;

   typedef struct {
      tok_type tok;
      logic    last;
   } token_word_type;

   localparam logic [63:0] MANT_LIMIT = (64'd1 << MANT_BITS) - 64'd1;
   localparam int unsigned FRAC_MAX   = 31;

   // Predicted converter state
   op_code_type    pend_ops [STACK_DEPTH];
   int unsigned    pend_depth;
   logic [63:0]    num_value;
   logic           num_open;
   logic           num_dot;
   int unsigned    num_frac;
   name_scan_type  name_scan;
   logic [25:0]    vars_seen;
   err_type        expr_err;

   tok_type        step_tokens[$];
   token_word_type tokens_due[$];

   initial begin
      mismatches     = 0;
      outstanding    = 0;
      tokens_checked = 0;
   end

   function void clear_expr_state();
      pend_depth = 0;
      num_value  = '0;
      num_open   = 1'b0;
      num_dot    = 1'b0;
      num_frac   = 0;
      name_scan  = NAME_IDLE;
      vars_seen  = '0;
      expr_err   = ERR_NONE;
   endfunction

   // Keep only the first error of an expression.
   function void note_error(err_type e);
      if (expr_err == ERR_NONE) expr_err = e;
   endfunction

   function void put_token(kind_type k, logic [31:0] m, logic [4:0] pd, logic [4:0] v,
                           logic f, op_code_type op, err_type e);
      tok_type t;
      t              = '0;
      t.kind         = k;
      t.mantissa     = m;
      t.point_digits = pd;
      t.var_index    = v;
      t.first_use    = f;
      t.op_code      = op;
      t.error_code   = e;
      step_tokens.push_back(t);
   endfunction

   function void pop_and_emit();
      pend_depth--;
      put_token(KIND_OP, '0, '0, '0, 1'b0, pend_ops[pend_depth], ERR_NONE);
   endfunction

   function void flush_number();
      if (num_open) put_token(KIND_NUM, num_value[31:0], 5'(num_frac), '0, 1'b0, '0, ERR_NONE);
      num_open  = 1'b0;
      num_dot   = 1'b0;
      num_value = '0;
      num_frac  = 0;
   endfunction

   function void push_code(op_code_type code);
      if (pend_depth < STACK_DEPTH) begin
         pend_ops[pend_depth] = code;
         pend_depth++;
      end else begin
         note_error(ERR_STACK);
      end
   endfunction

   // Binary op may rest on 'below' without popping it first.
   function bit stays_above(op_code_type op, op_code_type below);
      if (below == CODE_LP) return 1'b1;
      if (op == OP_MUL || op == OP_DIV) return (below == OP_ADD) || (below == OP_SUB);
      if (op == OP_POW) return below <= OP_POW;
      return 1'b0;
   endfunction

   function void push_binary(op_code_type op);
      while (pend_depth > 0 && !stays_above(op, pend_ops[pend_depth - 1])) pop_and_emit();
      push_code(op);
   endfunction

   function void close_group();
      op_code_type t;
      while (pend_depth > 0 && pend_ops[pend_depth - 1] != CODE_LP) pop_and_emit();
      if (pend_depth == 0) begin
         note_error(ERR_STRAY_RP);
         return;
      end
      pend_depth--;
      if (pend_depth > 0) begin
         t = pend_ops[pend_depth - 1];
         if (t >= OP_NEG && t <= OP_LN) pop_and_emit();
      end
   endfunction

   function void take_digit(logic [63:0] d);
      if (!num_open) begin
         num_open  = 1'b1;
         num_dot   = 1'b0;
         num_value = '0;
         num_frac  = 0;
      end
      if (num_dot) begin
         if (num_frac >= FRAC_MAX) return;
         num_frac++;
      end
      if (num_value > (MANT_LIMIT - d) / 10) begin
         num_value = MANT_LIMIT;
         note_error(ERR_NUMBER);
      end else begin
         num_value = num_value * 10 + d;
      end
   endfunction

   function void handle_char(logic [7:0] c);
      logic [4:0] v;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         take_digit(64'(c - CH_ZERO));
      end else if (c == CH_DOT) begin
         if (!num_open) begin
            num_open  = 1'b1;
            num_value = '0;
            num_frac  = 0;
            num_dot   = 1'b1;
         end else begin
            num_dot = 1'b1;
         end
      end else begin
         flush_number();
         if (c >= CH_A && c <= CH_Z) begin
            v = 5'(c - CH_A);
            put_token(KIND_VAR, '0, '0, v, !vars_seen[v], '0, ERR_NONE);
            vars_seen[v] = 1'b1;
         end else begin
            case (c)
               CH_PLUS:  push_binary(OP_ADD);
               CH_MINUS: push_binary(OP_SUB);
               CH_STAR:  push_binary(OP_MUL);
               CH_SLASH: push_binary(OP_DIV);
               CH_CARET: push_binary(OP_POW);
               CH_TILDE: push_code(OP_NEG);
               CH_LC_S:  name_scan = NAME_S_SEEN;
               CH_LC_C: begin
                  push_code(OP_COS);
                  name_scan = NAME_SKIP2;
               end
               CH_LC_L: begin
                  push_code(OP_LN);
                  name_scan = NAME_SKIP1;
               end
               CH_LP:    push_code(CODE_LP);
               CH_RP:    close_group();
               default:  ;
            endcase
         end
      end
   endfunction

   function void finish_expression();
      flush_number();
      while (pend_depth > 0) begin
         if (pend_ops[pend_depth - 1] == CODE_LP) begin
            pend_depth--;
            note_error(ERR_OPEN_LP);
         end else begin
            pop_and_emit();
         end
      end
      put_token(KIND_END, '0, '0, '0, 1'b0, '0, expr_err);
      clear_expr_state();
   endfunction

   function void predict_word(logic [7:0] c, logic eoe);
      token_word_type w;
      step_tokens.delete();
      case (name_scan)
         NAME_SKIP2: name_scan = NAME_SKIP1;
         NAME_SKIP1: name_scan = NAME_IDLE;
         NAME_S_SEEN: begin
            if (c == CH_LC_I) begin
               push_code(OP_SIN);
               name_scan = NAME_SKIP1;
            end else if (c == CH_LC_Q) begin
               push_code(OP_SQRT);
               name_scan = NAME_SKIP2;
            end else begin
               name_scan = NAME_IDLE;
               handle_char(c);
            end
         end
         default: handle_char(c);
      endcase
      if (eoe) finish_expression();
      foreach (step_tokens[i]) begin
         w.tok  = step_tokens[i];
         w.last = (i == step_tokens.size() - 1);
         tokens_due.push_back(w);
      end
   endfunction

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      token_word_type w;
      if (reset) begin
         clear_expr_state();
         tokens_due.delete();
      end else begin
         if (req_valid && req_ready) predict_word(req_char_code, req_end_of_expr);
         if (rsp_valid && rsp_ready) begin
            tokens_checked++;
            if (tokens_due.size() == 0) begin
               mismatches++;
               $display("%0t: token word mismatch: expected none, actual kind %0d op %0d",
                        $time, rsp_token_kind, rsp_op_code);
            end else begin
               w = tokens_due.pop_front();
               check_field("token_kind", 32'(w.tok.kind), 32'(rsp_token_kind));
               check_field("mantissa", w.tok.mantissa, rsp_mantissa);
               check_field("point_digits", 32'(w.tok.point_digits), 32'(rsp_point_digits));
               check_field("var_index", 32'(w.tok.var_index), 32'(rsp_var_index));
               check_field("first_use", 32'(w.tok.first_use), 32'(rsp_first_use));
               check_field("op_code", 32'(w.tok.op_code), 32'(rsp_op_code));
               check_field("error_code", 32'(w.tok.error_code), 32'(rsp_error_code));
               check_field("last_of_run", 32'(w.last), 32'(rsp_last_of_run));
            end
         end
      end
      outstanding = tokens_due.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the infix-to-postfix converter: clock, reset, character stimulus
// and token back-pressure; the verdict comes from the counts of itp_token_checker.
// Depends on itp_pkg, infix_to_postfix_converter_unit and itp_token_checker.
module tb_top;
   import itp_pkg::*;

   // Run shape: targets and trigger points counted in accepted character words
   localparam int ITEM_TARGET  = 350;
   localparam int HOLD_AT      = 120;   // start of the long token stall
   localparam int HOLD_CYCLES  = 400;
   localparam int PAUSE_AT     = 220;   // sender waits for every token here
   localparam int CALM_AT      = 300;   // no idling from here on
   localparam int DRAIN_CYCLES = 60;
   localparam int LIMIT_NS     = 8_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   char_type    req_char_code = '0;
   logic        req_end_of_expr = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_token_kind;
   logic [31:0] rsp_mantissa;
   logic [4:0]  rsp_point_digits;
   logic [4:0]  rsp_var_index;
   logic        rsp_first_use;
   logic [3:0]  rsp_op_code;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_of_run;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned tokens_checked;

   int unsigned chars_sent = 0;
   int unsigned exprs_sent = 0;
   bit          calm = 1'b0;
   bit          hold_done = 1'b0;
   char_type    expr_chars[$];

   always #5 clock = ~clock;

   infix_to_postfix_converter_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_expr  (req_end_of_expr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_mantissa     (rsp_mantissa),
      .rsp_point_digits (rsp_point_digits),
      .rsp_var_index    (rsp_var_index),
      .rsp_first_use    (rsp_first_use),
      .rsp_op_code      (rsp_op_code),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   itp_token_checker i_token_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_expr  (req_end_of_expr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_mantissa     (rsp_mantissa),
      .rsp_point_digits (rsp_point_digits),
      .rsp_var_index    (rsp_var_index),
      .rsp_first_use    (rsp_first_use),
      .rsp_op_code      (rsp_op_code),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .tokens_checked   (tokens_checked)
   );

   // Offer one character word. Drive at the falling edge, look for the handshake at the
   // rising edge. An optional idle burst drops valid first; without one, valid stays
   // high and only the payload moves on to the next word.
   task automatic send_char(char_type c, logic last, bit idle_ok);
      int gap;
      gap = 0;
      if (idle_ok && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_char_code   <= c;
      req_end_of_expr <= last;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   // Send the built expression, flag its last character as the end, then clear it.
   task automatic send_expr(bit idle_ok);
      foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1, idle_ok);
      expr_chars.delete();
      exprs_sent++;
   endtask

   // Drop valid and hold off until every predicted token has been seen.
   task automatic wait_for_tokens();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) expr_chars.push_back(char_type'(s[i]));
   endtask

   // Append a decimal number: integer digits, maybe a point and fraction digits,
   // now and then a second point that the converter must skip.
   task automatic put_number();
      int  int_digits;
      bit  with_point;
      int_digits = $urandom_range(0, 4);
      with_point = (int_digits == 0) || ($urandom_range(0, 2) == 0);
      repeat (int_digits) expr_chars.push_back(char_type'(CH_ZERO + $urandom_range(0, 9)));
      if (with_point) begin
         put_text(".");
         repeat ($urandom_range(0, 3))
            expr_chars.push_back(char_type'(CH_ZERO + $urandom_range(0, 9)));
         if ($urandom_range(0, 7) == 0) put_text(".5");
      end
   endtask

   // Append a well-formed expression: operands with optional prefixes and groups,
   // joined by binary operators. Letters lean toward A-D so repeats happen often.
   task automatic build_wellformed();
      int terms;
      int open;
      terms = $urandom_range(1, 5);
      open  = 0;
      for (int t = 0; t < terms; t++) begin
         while ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0: put_text("~");
               1: put_text("sin");
               2: put_text("cos");
               3: put_text("sqrt");
               4: put_text("ln");
               default: ;
            endcase
            // A prefix right before '(' is emitted when the group closes.
            if ($urandom_range(0, 1) == 0) begin
               put_text("(");
               open++;
            end
         end
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 1) == 0)
               expr_chars.push_back(char_type'(CH_A + $urandom_range(0, 3)));
            else
               expr_chars.push_back(char_type'(CH_A + $urandom_range(0, 25)));
         end else begin
            put_number();
         end
         while (open > 0 && $urandom_range(0, 2) == 0) begin
            put_text(")");
            open--;
         end
         if (t < terms - 1) begin
            case ($urandom_range(0, 4))
               0: put_text("+");
               1: put_text("-");
               2: put_text("*");
               3: put_text("/");
               default: put_text("^");
            endcase
         end
      end
      repeat (open) put_text(")");
   endtask

   // Characters that mean something to the converter, for noise that bites.
   string live_chars = "+-*/^~().sincoqlt0123456789AZ";

   initial begin : stimulus
      int  kind;
      int  idx;
      bit  paused;
      bit  idle_ok;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every operator and function, letter and character extremes,
      // a lone point, a stray close bracket.
      put_text("sqrt.+A*(B-C)");
      send_expr(1'b0);
      put_text("~sin(Z)^2");
      send_expr(1'b1);
      put_text("cosA/lnB");
      send_expr(1'b1);
      expr_chars.push_back(8'h00);
      send_expr(1'b1);
      expr_chars.push_back(8'hFF);
      send_expr(1'b1);
      put_text(")");
      send_expr(1'b1);
      wait_for_tokens();

      // Random: the first three expressions force stack overflow, number overflow and
      // a truncated fraction; the rest is mostly well-formed with noise mixed in.
      idx    = 0;
      paused = 1'b0;
      while (chars_sent < ITEM_TARGET) begin
         kind = (idx < 3) ? idx : $urandom_range(3, 99);
         if (kind == 0 || (kind >= 3 && kind <= 5)) begin
            // Deep nesting: past the stack depth when forced.
            repeat ((kind == 0) ? 34 : $urandom_range(28, 35)) put_text("(");
            put_text("A");
            repeat ($urandom_range(0, 3)) put_text(")");
         end else if (kind == 1 || (kind >= 6 && kind <= 8)) begin
            // Long integer: eleven digits or more saturate the mantissa.
            expr_chars.push_back(char_type'(CH_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(10, 13))
               expr_chars.push_back(char_type'(CH_ZERO + $urandom_range(0, 9)));
         end else if (kind == 2 || (kind >= 9 && kind <= 11)) begin
            // Long fraction: zeros keep the mantissa small, the tail gets truncated.
            put_text(".");
            repeat (28) put_text("0");
            repeat ($urandom_range(4, 6))
               expr_chars.push_back(char_type'(CH_ZERO + $urandom_range(0, 9)));
            put_text("+B");
         end else if (kind >= 12 && kind <= 14) begin
            // An 's' that may not start a function name.
            put_text("s");
            expr_chars.push_back(char_type'($urandom_range(0, 255)));
            put_text("B");
         end else if (kind >= 15 && kind <= 24) begin
            // Noise: raw bytes, half of them from the live set.
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 1) == 0)
                  expr_chars.push_back(char_type'($urandom_range(0, 255)));
               else
                  expr_chars.push_back(
                     char_type'(live_chars[$urandom_range(0, live_chars.len() - 1)]));
            end
         end else if (kind >= 25 && kind <= 34) begin
            // Broken: a stray close, an unclosed group, a stray byte or a lost char.
            build_wellformed();
            case ($urandom_range(0, 3))
               0: expr_chars.insert($urandom_range(0, expr_chars.size()), CH_RP);
               1: put_text("*(C");
               2: expr_chars.insert($urandom_range(0, expr_chars.size()),
                                    char_type'($urandom_range(0, 255)));
               default: expr_chars.delete($urandom_range(0, expr_chars.size() - 1));
            endcase
            if (expr_chars.size() == 0) put_text(".");
         end else begin
            build_wellformed();
         end
         idle_ok = calm ? 1'b0 : ($urandom_range(0, 2) != 0);
         send_expr(idle_ok);
         idx++;
         if (!paused && chars_sent >= PAUSE_AT) begin
            paused = 1'b1;
            wait_for_tokens();
         end
         if (chars_sent >= CALM_AT) calm = 1'b1;
      end

      // Drain, then give the block time for any stray word.
      wait_for_tokens();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d characters in %0d expressions, %0d tokens compared.",
               chars_sent, exprs_sent, tokens_checked);
      $display("Mix: nesting past stack depth, saturated and truncated numbers, noise.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Token sink: random stall bursts and ready runs, one long stall while the sender
   // keeps offering words so the block backs up, and steady ready near the end.
   initial begin : token_sink
      @(negedge clock);
      forever begin
         if (!hold_done && chars_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #(LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
sv/itp_pkg.sv
sv/itp_stack_cell.sv
sv/itp_op_stack.sv
sv/infix_to_postfix_converter_unit.sv
dv/itp_token_checker.sv
dv/tb_top.sv
